// ===== src/pvd_pkg.sv =====
// ----------------------------------------------------------------------------
// pvd_pkg: shared types and tables for the prefix varint decoder
// Holds the decoder state record, the result record, status codes and the
// per-format length and mask tables.
// ----------------------------------------------------------------------------
`default_nettype none

package pvd_pkg;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CLASS_W     = 3;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 72;  // value + length_bytes, padded to bytes
  localparam int unsigned OUT_TUSER_W = STATUS_W;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNSUPPORTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TRUNCATED   = 2'd2;

  // format classes chosen by the leading byte
  localparam logic [CLASS_W-1:0] CLS_2B   = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_3B   = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_4B   = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_5B   = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_8B   = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_F8   = 3'd5;
  localparam logic [CLASS_W-1:0] CLS_F9   = 3'd6;
  localparam logic [CLASS_W-1:0] CLS_BAD  = 3'd7;

  // decoder state carried between bytes
  typedef struct packed {
    logic [VALUE_W-1:0] acc;
    logic [LEN_W-1:0]   rem;
    logic [CLASS_W-1:0] cls;
    logic [LEN_W-1:0]   taken;
  } state_t;

  // one decoded result
  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    len;
  } result_t;

  // format class of a leading byte with the top bit set
  function automatic logic [CLASS_W-1:0] classify(input logic [7:0] b);
    logic [CLASS_W-1:0] c;
    if (b <= 8'hBF)      c = CLS_2B;
    else if (b <= 8'hDF) c = CLS_3B;
    else if (b <= 8'hE7) c = CLS_4B;
    else if (b <= 8'hEF) c = CLS_5B;
    else if (b <= 8'hF7) c = CLS_8B;
    else if (b == 8'hF8) c = CLS_F8;
    else if (b == 8'hF9) c = CLS_F9;
    else                 c = CLS_BAD;
    return c;
  endfunction

  // total byte count of a format
  function automatic logic [LEN_W-1:0] class_length(input logic [CLASS_W-1:0] c);
    logic [LEN_W-1:0] n;
    unique case (c)
      CLS_2B:  n = 4'd2;
      CLS_3B:  n = 4'd3;
      CLS_4B:  n = 4'd4;
      CLS_5B:  n = 4'd5;
      CLS_8B:  n = 4'd8;
      CLS_F8:  n = 4'd6;
      CLS_F9:  n = 4'd9;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // bits kept by a format
  function automatic logic [VALUE_W-1:0] class_mask(input logic [CLASS_W-1:0] c);
    logic [VALUE_W-1:0] m;
    unique case (c)
      CLS_2B:  m = 64'h0000_0000_0000_3FFF;
      CLS_3B:  m = 64'h0000_0000_001F_FFFF;
      CLS_4B:  m = 64'h0000_0000_07FF_FFFF;
      CLS_5B:  m = 64'h0000_0007_FFFF_FFFF;
      CLS_8B:  m = 64'h07FF_FFFF_FFFF_FFFF;
      CLS_F8:  m = 64'h0000_00FF_FFFF_FFFF;
      CLS_F9:  m = 64'hFFFF_FFFF_FFFF_FFFF;
      default: m = 64'h0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== src/pvd_step.sv =====
// ----------------------------------------------------------------------------
// pvd_step: one-byte decode step
// Combinational next-state and result logic for a single input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pvd_step (
  input  wire pvd_pkg::state_t  st,
  input  wire logic [7:0]       data_byte,
  input  wire logic             buffer_end,
  output pvd_pkg::state_t       st_nxt,
  output logic                  emit,
  output pvd_pkg::result_t      res
);

  pvd_pkg::state_t            idle_st;
  logic [pvd_pkg::CLASS_W-1:0] cls;
  logic [pvd_pkg::VALUE_W-1:0] acc_sh;
  logic [pvd_pkg::LEN_W-1:0]   taken_inc;
  logic [pvd_pkg::LEN_W-1:0]   rem_dec;

  assign idle_st   = '0;
  assign cls       = pvd_pkg::classify(data_byte);
  assign acc_sh    = {st.acc[pvd_pkg::VALUE_W-9:0], data_byte};
  assign taken_inc = st.taken + 4'd1;
  assign rem_dec   = st.rem - 4'd1;

  // decode one byte
  always_comb begin
    st_nxt     = idle_st;
    emit       = 1'b0;
    res.value  = '0;
    res.status = pvd_pkg::STATUS_OK;
    res.len    = 4'd1;
    if (st.rem == 4'd0) begin
      // leading byte
      if (!data_byte[7]) begin
        emit      = 1'b1;
        res.value = {56'd0, data_byte};
      end else if (cls == pvd_pkg::CLS_BAD) begin
        emit       = 1'b1;
        res.status = pvd_pkg::STATUS_UNSUPPORTED;
      end else if (buffer_end) begin
        emit       = 1'b1;
        res.status = pvd_pkg::STATUS_TRUNCATED;
      end else begin
        st_nxt.acc   = {56'd0, data_byte};
        st_nxt.cls   = cls;
        st_nxt.taken = 4'd1;
        st_nxt.rem   = pvd_pkg::class_length(cls) - 4'd1;
      end
    end else begin
      // continuation byte
      res.len = taken_inc;
      if (rem_dec == 4'd0) begin
        emit      = 1'b1;
        res.value = acc_sh & pvd_pkg::class_mask(st.cls);
      end else if (buffer_end) begin
        emit       = 1'b1;
        res.status = pvd_pkg::STATUS_TRUNCATED;
      end else begin
        st_nxt.acc   = acc_sh;
        st_nxt.cls   = st.cls;
        st_nxt.taken = taken_inc;
        st_nxt.rem   = rem_dec;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/prefix_varint_decoder_core.sv =====
// ----------------------------------------------------------------------------
// prefix_varint_decoder_core: prefix-length varint stream decoder
// Takes one encoded byte per item and returns one decoded value per
// complete, unsupported or truncated integer.
// ----------------------------------------------------------------------------
// The decoder accepts one byte every cycle for as long as the result side
// keeps up. A byte is captured in an input register, decoded by a single
// step of combinational logic while it sits there, and a finished result
// sits in an output register. The input register also serves as the
// skid stage, so a byte can still be taken while a result waits; when the
// result side stalls with a result waiting, bytes that do not close a value
// keep flowing, and the input side stalls once a byte that closes a value
// sits in the input register. Only the closing byte of a value (or an
// unsupported leading byte, or a byte that ends the buffer before a value
// is complete) produces a result.
`default_nettype none

module prefix_varint_decoder_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [pvd_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] data_byte
  input  wire logic                             in_tlast,   // buffer_end
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [pvd_pkg::OUT_TDATA_W-1:0]       out_tdata,  // [63:0] value, [67:64] length_bytes
  output logic [pvd_pkg::OUT_TUSER_W-1:0]       out_tuser   // [1:0] status
);

  logic             in_vld_r;
  logic [7:0]       in_byte_r;
  logic             in_last_r;
  pvd_pkg::state_t  st_r;
  pvd_pkg::state_t  st_nxt;
  logic             emit;
  pvd_pkg::result_t res;
  logic             out_vld_r;
  pvd_pkg::result_t out_r;
  logic             proc;

  // decode step
  pvd_step u_step (
    .st         (st_r),
    .data_byte  (in_byte_r),
    .buffer_end (in_last_r),
    .st_nxt     (st_nxt),
    .emit       (emit),
    .res        (res)
  );

  // a byte moves on unless its result would hit a full, stalled output
  assign proc      = in_vld_r && (!emit || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || proc;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata[7:0];
      in_last_r <= in_tlast;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (proc && emit) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, out_r.len, out_r.value};
  assign out_tuser  = out_r.status;

  // checks
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.rem <= 4'd8)
    else $error("bytes remaining out of range");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.len >= 4'd1 && out_r.len <= 4'd9))
    else $error("length_bytes out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.status != pvd_pkg::STATUS_OK) |-> out_r.value == '0)
    else $error("error result carries a nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.status == pvd_pkg::STATUS_OK ||
                   out_r.status == pvd_pkg::STATUS_UNSUPPORTED ||
                   out_r.status == pvd_pkg::STATUS_TRUNCATED))
    else $error("bad status code");

  a_unsup_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.status == pvd_pkg::STATUS_UNSUPPORTED) |-> out_r.len == 4'd1)
    else $error("unsupported result with length other than one");

endmodule

`default_nettype wire

// ===== bench/prefix_varint_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// prefix_varint_decoder_core_tb: self-checking bench for the varint decoder
// Streams encoded bytes into the decoder with random gaps on both sides,
// predicts every decoded value from its own byte-level decoder and compares
// each result item field by field in arrival order.
// ----------------------------------------------------------------------------
module prefix_varint_decoder_core_tb;

  // byte-level decoder model plus the queue of values still owed
  class varint_tracker;
    pvd_pkg::state_t  dec;
    pvd_pkg::result_t owed[$];
    int               errors;
    int               n_ok;
    int               n_unsup;
    int               n_trunc;

    function new();
      dec = '0;
      errors = 0;
      n_ok = 0;
      n_unsup = 0;
      n_trunc = 0;
    endfunction

    // total bytes of a format
    static function logic [pvd_pkg::LEN_W-1:0] span(logic [pvd_pkg::CLASS_W-1:0] c);
      case (c)
        pvd_pkg::CLS_2B:  return 4'd2;
        pvd_pkg::CLS_3B:  return 4'd3;
        pvd_pkg::CLS_4B:  return 4'd4;
        pvd_pkg::CLS_5B:  return 4'd5;
        pvd_pkg::CLS_8B:  return 4'd8;
        pvd_pkg::CLS_F8:  return 4'd6;
        pvd_pkg::CLS_F9:  return 4'd9;
        default:          return 4'd0;
      endcase
    endfunction

    // low bits kept by a format
    static function logic [pvd_pkg::VALUE_W-1:0] keep(logic [pvd_pkg::CLASS_W-1:0] c);
      int bits;
      case (c)
        pvd_pkg::CLS_2B:  bits = 14;
        pvd_pkg::CLS_3B:  bits = 21;
        pvd_pkg::CLS_4B:  bits = 27;
        pvd_pkg::CLS_5B:  bits = 35;
        pvd_pkg::CLS_8B:  bits = 59;
        pvd_pkg::CLS_F8:  bits = 40;
        default:          bits = 64;
      endcase
      if (bits == 64) return '1;
      return (64'd1 << bits) - 64'd1;
    endfunction

    function void owe(logic [pvd_pkg::VALUE_W-1:0] v,
                      logic [pvd_pkg::STATUS_W-1:0] s,
                      logic [pvd_pkg::LEN_W-1:0] n);
      pvd_pkg::result_t r;
      r.value = v;
      r.status = s;
      r.len = n;
      owed.push_back(r);
      dec = '0;
    endfunction

    // one accepted byte
    function void take_byte(logic [7:0] b, logic at_end);
      logic [pvd_pkg::CLASS_W-1:0] c;
      if (dec.rem == '0) begin
        // leading byte
        if (!b[7]) begin
          owe({56'd0, b}, pvd_pkg::STATUS_OK, 4'd1);
          return;
        end
        if (b < 8'hC0)       c = pvd_pkg::CLS_2B;
        else if (b < 8'hE0)  c = pvd_pkg::CLS_3B;
        else if (b < 8'hE8)  c = pvd_pkg::CLS_4B;
        else if (b < 8'hF0)  c = pvd_pkg::CLS_5B;
        else if (b < 8'hF8)  c = pvd_pkg::CLS_8B;
        else if (b == 8'hF8) c = pvd_pkg::CLS_F8;
        else if (b == 8'hF9) c = pvd_pkg::CLS_F9;
        else                 c = pvd_pkg::CLS_BAD;
        if (c == pvd_pkg::CLS_BAD) owe('0, pvd_pkg::STATUS_UNSUPPORTED, 4'd1);
        else if (at_end) owe('0, pvd_pkg::STATUS_TRUNCATED, 4'd1);
        else begin
          dec.acc = {56'd0, b};
          dec.cls = c;
          dec.taken = 4'd1;
          dec.rem = span(c) - 4'd1;
        end
        return;
      end
      // continuation byte
      dec.acc = {dec.acc[pvd_pkg::VALUE_W-9:0], b};
      dec.taken = dec.taken + 4'd1;
      dec.rem = dec.rem - 4'd1;
      if (dec.rem == '0) owe(dec.acc & keep(dec.cls), pvd_pkg::STATUS_OK, dec.taken);
      else if (at_end) owe('0, pvd_pkg::STATUS_TRUNCATED, dec.taken);
    endfunction

    // one accepted result item
    function void check_value(logic [pvd_pkg::OUT_TDATA_W-1:0] td,
                              logic [pvd_pkg::OUT_TUSER_W-1:0] tu);
      pvd_pkg::result_t w;
      if (owed.size() == 0) begin
        $error("unexpected result: value %h status %0d length %0d",
               td[63:0], tu, td[67:64]);
        errors++;
        return;
      end
      w = owed.pop_front();
      if (td[63:0] !== w.value) begin
        $error("value mismatch: expected %h, got %h", w.value, td[63:0]);
        errors++;
      end
      if (tu !== w.status) begin
        $error("status mismatch: expected %0d, got %0d", w.status, tu);
        errors++;
      end
      if (td[67:64] !== w.len) begin
        $error("length_bytes mismatch: expected %0d, got %0d", w.len, td[67:64]);
        errors++;
      end
      case (w.status)
        pvd_pkg::STATUS_OK:          n_ok++;
        pvd_pkg::STATUS_UNSUPPORTED: n_unsup++;
        default:                     n_trunc++;
      endcase
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [pvd_pkg::IN_TDATA_W-1:0]  in_tdata;   // [7:0] data_byte
  logic                            in_tlast;   // buffer_end
  logic                            out_tvalid;
  logic                            out_tready;
  logic [pvd_pkg::OUT_TDATA_W-1:0] out_tdata;  // [63:0] value, [67:64] length_bytes
  logic [pvd_pkg::OUT_TUSER_W-1:0] out_tuser;  // [1:0] status

  varint_tracker tracker;
  int            n_bytes;
  int            n_seen;
  bit            held_off;

  prefix_varint_decoder_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock, period 10
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("prefix_varint_decoder_core regression: fail");
    $finish;
  end

  // offer one byte, starting and ending at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic at_end);
    int gap;
    gap = ((n_bytes / 40) % 3 == 2) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= at_end;
    do @(posedge clk); while (!in_tready);
    tracker.take_byte(b, at_end);
    n_bytes++;
    @(negedge clk);
  endtask

  // one multi-byte value of format fmt with random content; cut > 0 ends the
  // buffer after that many bytes, before the value is complete
  task automatic send_value(input int fmt, input int cut);
    logic [7:0] lead;
    int         n;
    logic       at_end;
    case (fmt)
      0:       begin lead = 8'($urandom_range(8'h80, 8'hBF)); n = 2; end
      1:       begin lead = 8'($urandom_range(8'hC0, 8'hDF)); n = 3; end
      2:       begin lead = 8'($urandom_range(8'hE0, 8'hE7)); n = 4; end
      3:       begin lead = 8'($urandom_range(8'hE8, 8'hEF)); n = 5; end
      4:       begin lead = 8'($urandom_range(8'hF0, 8'hF7)); n = 8; end
      5:       begin lead = 8'hF8; n = 6; end
      default: begin lead = 8'hF9; n = 9; end
    endcase
    if (cut > 0 && cut >= n) cut = n - 1;
    for (int i = 1; i <= n; i++) begin
      if (cut > 0) at_end = (i == cut);
      else at_end = (i == n) && ($urandom_range(0, 7) == 0);
      push_byte((i == 1) ? lead : 8'($urandom), at_end);
      if (cut > 0 && i == cut) break;
    end
  endtask

  // result side: random stalls, one long hold-off
  initial begin
    int gap;
    out_tready = 1'b0;
    n_seen = 0;
    held_off = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (n_seen == 120 && !held_off) begin
        gap = 300;
        held_off = 1;
      end else begin
        gap = ((n_seen / 32) % 3 == 1) ? 0 : $urandom_range(0, 8);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_value(out_tdata, out_tuser);
      n_seen++;
      @(negedge clk);
    end
  end

  // reset, stimulus, drain and verdict
  initial begin
    int kind;
    int fmt;
    int spin;
    tracker = new();
    n_bytes = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: single bytes, unsupported leads, early buffer ends, widest formats
    push_byte(8'h7F, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFA, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h80, 1'b1);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hFF, 1'b0);
    for (int i = 0; i < 9; i++) push_byte(i == 0 ? 8'hF9 : 8'hFF, i == 8);
    push_byte(8'hF8, 1'b0);
    push_byte(8'h80, 1'b0);
    for (int i = 0; i < 3; i++) push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hE8, 1'b0);
    push_byte(8'h12, 1'b1);

    // random: mostly well-formed values, some cut short, some noise
    while (n_bytes < 720) begin
      kind = $urandom_range(0, 99);
      fmt = $urandom_range(0, 6);
      if (kind < 20) push_byte(8'($urandom_range(0, 8'h7F)), 1'($urandom_range(0, 1)));
      else if (kind < 82) send_value(fmt, 0);
      else if (kind < 92) send_value(fmt, $urandom_range(1, 8));
      else if (kind < 96) push_byte(8'($urandom_range(8'hFA, 8'hFF)), 1'($urandom_range(0, 1)));
      else push_byte(8'($urandom), 1'($urandom_range(0, 1)));
    end
    in_tvalid <= 1'b0;

    // drain
    spin = 0;
    while (tracker.owed.size() != 0 && spin < 5000) begin
      @(posedge clk);
      spin++;
    end
    repeat (16) @(posedge clk);
    if (tracker.owed.size() != 0) begin
      $error("%0d expected results never arrived", tracker.owed.size());
      tracker.errors++;
    end

    $display("sent %0d encoded bytes, checked %0d results (%0d ok, %0d unsupported, %0d truncated)",
             n_bytes, n_seen, tracker.n_ok, tracker.n_unsup, tracker.n_trunc);
    $display("result side held off once for 300 cycles to back up the input");
    if (tracker.errors == 0) $display("prefix_varint_decoder_core regression: pass");
    else $display("prefix_varint_decoder_core regression: fail");
    $finish;
  end

endmodule
